// File: sv/intel_hex_record_parser_macros.svh
// Assertion helpers shared by the parser RTL.
// Both expect the enclosing module to have clk and an active-low rst_n.
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// Same-cycle implication.
`define IHEX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("intel_hex_record_parser: same-cycle check failed");

// Next-cycle implication.
`define IHEX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("intel_hex_record_parser: next-cycle check failed");

`endif

// File: sv/ihex_pkg.sv
`timescale 1ns / 1ps

package ihex_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;

    localparam logic       KIND_DATA = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

    localparam logic [7:0] REC_EXT_LINEAR   = 8'h04;
    localparam logic [7:0] REC_START_LINEAR = 8'h05;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// File: sv/intel_hex_record_parser.sv
`timescale 1ns / 1ps
// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_ready  | ch
// out     | out_valid / out_ready| kind, byte_index, byte_value, status,
//         |                      | record_type, record_length, resolved_address,
//         |                      | computed_checksum, received_checksum
//
// One character is taken per cycle unless out stalls; each result is registered in the
// result register. The rate is set by the single decode-and-update step between the
// input register and the result register. A stall on out holds the result register;
// the input register, if empty, then takes one more character and in_ready drops.
// Reset clears the parser to wait for a colon with a zero base address.

module intel_hex_record_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  byte_index,
    output logic [7:0]  byte_value,
    output logic [1:0]  status,
    output logic [7:0]  record_type,
    output logic [7:0]  record_length,
    output logic [31:0] resolved_address,
    output logic [7:0]  computed_checksum,
    output logic [7:0]  received_checksum
);

`include "intel_hex_record_parser_macros.svh"

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_CSUM
    } phase_t;

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  ch_reg, ch_next;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        nibble_pending_reg, nibble_pending_next;
    logic [1:0]  field_byte_count_reg, field_byte_count_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] load_address_reg, load_address_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  data_count_reg, data_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [31:0] first_four_reg, first_four_next;
    logic [31:0] base_address_reg, base_address_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [7:0]  byte_value_reg, byte_value_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  record_type_reg, record_type_next;
    logic [7:0]  record_length_reg, record_length_next;
    logic [31:0] resolved_address_reg, resolved_address_next;
    logic [7:0]  computed_checksum_reg, computed_checksum_next;
    logic [7:0]  received_checksum_reg, received_checksum_next;

    logic        step;
    logic [4:0]  hex_dec;
    logic [7:0]  byte_val;
    logic [7:0]  comp_sum;

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    assign hex_dec  = ihex_pkg::hex_decode(ch_reg);
    assign byte_val = {high_nibble_reg, hex_dec[3:0]};
    assign comp_sum = 8'(8'h00 - running_sum_reg) & ihex_pkg::BYTE_MASK;

    always_comb
    begin
        in_valid_next = in_ready ? in_valid : in_valid_reg;
        ch_next       = (in_valid && in_ready) ? ch : ch_reg;

        phase_next            = phase_reg;
        high_nibble_next      = high_nibble_reg;
        nibble_pending_next   = nibble_pending_reg;
        field_byte_count_next = field_byte_count_reg;
        length_next           = length_reg;
        load_address_next     = load_address_reg;
        type_next             = type_reg;
        data_count_next       = data_count_reg;
        running_sum_next      = running_sum_reg;
        first_four_next       = first_four_reg;
        base_address_next     = base_address_reg;

        out_valid_next         = out_valid_reg && !out_ready;
        kind_next              = kind_reg;
        byte_index_next        = byte_index_reg;
        byte_value_next        = byte_value_reg;
        status_next            = status_reg;
        record_type_next       = record_type_reg;
        record_length_next     = record_length_reg;
        resolved_address_next  = resolved_address_reg;
        computed_checksum_next = computed_checksum_reg;
        received_checksum_next = received_checksum_reg;

        if (step)
        begin
            if (ch_reg == ihex_pkg::COLON_CHAR)
            begin
                phase_next            = PH_LEN;
                high_nibble_next      = 4'h0;
                nibble_pending_next   = 1'b0;
                field_byte_count_next = 2'd0;
                length_next           = 8'h00;
                load_address_next     = 16'h0000;
                type_next             = 8'h00;
                data_count_next       = 8'h00;
                running_sum_next      = 8'h00;
                first_four_next       = 32'h0;
            end
            else if (phase_reg == PH_WAIT)
            begin
                phase_next = PH_WAIT;
            end
            else if (!hex_dec[4])
            begin
                // A stray character inside a record aborts it.
                phase_next             = PH_WAIT;
                nibble_pending_next    = 1'b0;
                out_valid_next         = 1'b1;
                kind_next              = ihex_pkg::KIND_END;
                byte_index_next        = 8'h00;
                byte_value_next        = 8'h00;
                status_next            = ihex_pkg::STATUS_BAD_CHAR;
                record_type_next       = type_reg;
                record_length_next     = length_reg;
                resolved_address_next  = 32'h0;
                computed_checksum_next = 8'h00;
                received_checksum_next = 8'h00;
            end
            else if (!nibble_pending_reg)
            begin
                high_nibble_next    = hex_dec[3:0];
                nibble_pending_next = 1'b1;
            end
            else
            begin
                nibble_pending_next = 1'b0;
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        length_next           = byte_val;
                        running_sum_next      = 8'(running_sum_reg + byte_val);
                        field_byte_count_next = 2'd0;
                        phase_next            = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        load_address_next     = {load_address_reg[7:0], byte_val};
                        running_sum_next      = 8'(running_sum_reg + byte_val);
                        field_byte_count_next = 2'(field_byte_count_reg + 2'd1);
                        if (field_byte_count_reg == 2'd1)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next        = byte_val;
                        running_sum_next = 8'(running_sum_reg + byte_val);
                        data_count_next  = 8'h00;
                        phase_next       = (length_reg == 8'h00) ? PH_CSUM : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        running_sum_next = 8'(running_sum_reg + byte_val);
                        if (data_count_reg < 8'd4)
                        begin
                            first_four_next = first_four_reg
                                | ({byte_val, 24'h0} >> {data_count_reg[1:0], 3'b000});
                        end
                        out_valid_next         = 1'b1;
                        kind_next              = ihex_pkg::KIND_DATA;
                        byte_index_next        = data_count_reg;
                        byte_value_next        = byte_val;
                        status_next            = ihex_pkg::STATUS_OK;
                        record_type_next       = 8'h00;
                        record_length_next     = 8'h00;
                        resolved_address_next  = 32'h0;
                        computed_checksum_next = 8'h00;
                        received_checksum_next = 8'h00;
                        data_count_next        = 8'(data_count_reg + 8'd1);
                        if (8'(data_count_reg + 8'd1) == length_reg)
                        begin
                            phase_next = PH_CSUM;
                        end
                    end
                    PH_CSUM:
                    begin
                        phase_next             = PH_WAIT;
                        out_valid_next         = 1'b1;
                        kind_next              = ihex_pkg::KIND_END;
                        byte_index_next        = 8'h00;
                        byte_value_next        = 8'h00;
                        record_type_next       = type_reg;
                        record_length_next     = length_reg;
                        computed_checksum_next = comp_sum;
                        received_checksum_next = byte_val;
                        if (comp_sum != byte_val)
                        begin
                            status_next           = ihex_pkg::STATUS_CSUM_ERR;
                            resolved_address_next = 32'h0;
                        end
                        else
                        begin
                            status_next = ihex_pkg::STATUS_OK;
                            priority if (type_reg == ihex_pkg::REC_EXT_LINEAR)
                            begin
                                base_address_next     = {first_four_reg[31:16], 16'h0000};
                                resolved_address_next = {first_four_reg[31:16], 16'h0000};
                            end
                            else if (type_reg == ihex_pkg::REC_START_LINEAR)
                            begin
                                resolved_address_next = first_four_reg;
                            end
                            else
                            begin
                                resolved_address_next =
                                    32'(base_address_reg + {16'h0000, load_address_reg});
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            ch_reg                <= 8'h00;
            phase_reg             <= PH_WAIT;
            high_nibble_reg       <= 4'h0;
            nibble_pending_reg    <= 1'b0;
            field_byte_count_reg  <= 2'd0;
            length_reg            <= 8'h00;
            load_address_reg      <= 16'h0000;
            type_reg              <= 8'h00;
            data_count_reg        <= 8'h00;
            running_sum_reg       <= 8'h00;
            first_four_reg        <= 32'h0;
            base_address_reg      <= 32'h0;
            out_valid_reg         <= 1'b0;
            kind_reg              <= ihex_pkg::KIND_DATA;
            byte_index_reg        <= 8'h00;
            byte_value_reg        <= 8'h00;
            status_reg            <= ihex_pkg::STATUS_OK;
            record_type_reg       <= 8'h00;
            record_length_reg     <= 8'h00;
            resolved_address_reg  <= 32'h0;
            computed_checksum_reg <= 8'h00;
            received_checksum_reg <= 8'h00;
        end
        else
        begin
            in_valid_reg          <= in_valid_next;
            ch_reg                <= ch_next;
            phase_reg             <= phase_next;
            high_nibble_reg       <= high_nibble_next;
            nibble_pending_reg    <= nibble_pending_next;
            field_byte_count_reg  <= field_byte_count_next;
            length_reg            <= length_next;
            load_address_reg      <= load_address_next;
            type_reg              <= type_next;
            data_count_reg        <= data_count_next;
            running_sum_reg       <= running_sum_next;
            first_four_reg        <= first_four_next;
            base_address_reg      <= base_address_next;
            out_valid_reg         <= out_valid_next;
            kind_reg              <= kind_next;
            byte_index_reg        <= byte_index_next;
            byte_value_reg        <= byte_value_next;
            status_reg            <= status_next;
            record_type_reg       <= record_type_next;
            record_length_reg     <= record_length_next;
            resolved_address_reg  <= resolved_address_next;
            computed_checksum_reg <= computed_checksum_next;
            received_checksum_reg <= received_checksum_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign byte_index        = byte_index_reg;
    assign byte_value        = byte_value_reg;
    assign status            = status_reg;
    assign record_type       = record_type_reg;
    assign record_length     = record_length_reg;
    assign resolved_address  = resolved_address_reg;
    assign computed_checksum = computed_checksum_reg;
    assign received_checksum = received_checksum_reg;

    // A data-byte result carries no record summary.
    `IHEX_ASSERT_SAME(a_data_result_clean,
        out_valid_reg && kind_reg == ihex_pkg::KIND_DATA,
        status_reg == ihex_pkg::STATUS_OK && resolved_address_reg == 32'h0)

    // A checksum error is reported only when the two checksums differ.
    `IHEX_ASSERT_SAME(a_csum_err_differs,
        out_valid_reg && kind_reg == ihex_pkg::KIND_END
            && status_reg == ihex_pkg::STATUS_CSUM_ERR,
        computed_checksum_reg != received_checksum_reg)

    // A good record end has matching checksums.
    `IHEX_ASSERT_SAME(a_ok_end_matches,
        out_valid_reg && kind_reg == ihex_pkg::KIND_END && status_reg == ihex_pkg::STATUS_OK,
        computed_checksum_reg == received_checksum_reg)

    // A colon always restarts the record from a clean length field.
    `IHEX_ASSERT_NEXT(a_colon_restarts,
        step && ch_reg == ihex_pkg::COLON_CHAR,
        phase_reg == PH_LEN && !nibble_pending_reg && running_sum_reg == 8'h00)

    // No half byte is held while waiting for a colon.
    `IHEX_ASSERT_SAME(a_wait_no_nibble, phase_reg == PH_WAIT, !nibble_pending_reg)

endmodule
